// ===== design/pnf_pkg.sv =====
// ----------------------------------------------------------------------------
// pnf_pkg: shared types and constants for the projectile net force pipeline
// Word formats, coefficient format, wide sum width and the pipeline payloads.
// ----------------------------------------------------------------------------
package pnf_pkg;

  // drag and magnus coefficients are unsigned Q8.24
  localparam int COEFF_FRAC_BITS = 24;
  // exact sum of magnus, drag and gravity terms fits well inside this
  localparam int SUM_W = 100;
  // square root result bits resolved per pipeline stage
  localparam int ROOT_ITERS = 2;
  localparam int ROOT_STAGES = 32 / ROOT_ITERS;

  typedef logic signed [31:0] val_t;

  // configuration register indices
  typedef enum logic [1:0] {
    CFG_GRAVITY = 2'd0,
    CFG_DRAG    = 2'd1,
    CFG_MAGNUS  = 2'd2
  } cfg_idx_t;

  // folded physical constants
  typedef struct packed {
    val_t        gravity;
    logic [31:0] drag;
    logic [31:0] magnus;
  } pnf_coef_t;

  // word travelling through the square root stages
  typedef struct packed {
    logic [63:0]       rem;
    logic [63:0]       root;
    val_t [2:0]        vel;
    logic [2:0]        cneg;
    logic [2:0][63:0]  cmag;
  } pnf_root_t;

endpackage

// ===== design/pnf_if.sv =====
// ----------------------------------------------------------------------------
// pnf_if: channel interfaces
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface pnf_in_if;
  import pnf_pkg::*;
  logic valid;
  logic ready;
  val_t vel_x;
  val_t vel_y;
  val_t vel_z;
  val_t spin_x;
  val_t spin_y;
  val_t spin_z;
  modport source (output valid, vel_x, vel_y, vel_z, spin_x, spin_y, spin_z,
                  input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, spin_x, spin_y, spin_z,
                output ready);
endinterface

interface pnf_out_if;
  import pnf_pkg::*;
  logic valid;
  logic ready;
  val_t force_x;
  val_t force_y;
  val_t force_z;
  logic overflow;
  modport source (output valid, force_x, force_y, force_z, overflow, input ready);
  modport sink (input valid, force_x, force_y, force_z, overflow, output ready);
endinterface

interface pnf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== design/pnf_front.sv =====
// ----------------------------------------------------------------------------
// pnf_front: squares and cross product
// Two stages: component products, then sum of squares and signed cross terms.
// ----------------------------------------------------------------------------
module pnf_front
  import pnf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pnf_in_if.sink     item_in,
  output logic       dn_valid,
  input  logic       dn_ready,
  output pnf_root_t  dn_data
);

  val_t                     v_in [3];
  val_t                     w_in [3];
  logic                     a_vld;
  logic                     a_rdy;
  logic [2:0][63:0]         a_sq;
  logic signed [63:0]       a_c1 [3];
  logic signed [63:0]       a_c2 [3];
  val_t [2:0]               a_vel;
  logic                     b_rdy;
  logic signed [64:0]       diff [3];

  assign v_in[0] = item_in.vel_x;
  assign v_in[1] = item_in.vel_y;
  assign v_in[2] = item_in.vel_z;
  assign w_in[0] = item_in.spin_x;
  assign w_in[1] = item_in.spin_y;
  assign w_in[2] = item_in.spin_z;

  // stage ready chain
  assign b_rdy = !dn_valid || dn_ready;
  assign a_rdy = !a_vld || b_rdy;
  assign item_in.ready = a_rdy;

  // stage a: squares and the two products of each cross component
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_rdy) begin
      a_vld <= item_in.valid;
    end
    if (a_rdy) begin
      for (int i = 0; i < 3; i++) begin
        a_sq[i]  <= 64'(v_in[i]) * 64'(v_in[i]);
        a_c1[i]  <= w_in[(i + 1) % 3] * v_in[(i + 2) % 3];
        a_c2[i]  <= w_in[(i + 2) % 3] * v_in[(i + 1) % 3];
        a_vel[i] <= v_in[i];
      end
    end
  end

  // exact cross difference, 65 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {a_c1[i][63], a_c1[i]} - {a_c2[i][63], a_c2[i]};
    end
  end

  // stage b: sum of squares, cross sign and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (b_rdy) begin
      dn_valid <= a_vld;
    end
    if (b_rdy) begin
      dn_data.rem  <= a_sq[0] + a_sq[1] + a_sq[2];
      dn_data.root <= '0;
      dn_data.vel  <= a_vel;
      for (int i = 0; i < 3; i++) begin
        dn_data.cneg[i] <= diff[i][64];
        dn_data.cmag[i] <= diff[i][64] ? 64'(-diff[i]) : diff[i][63:0];
      end
    end
  end

endmodule

// ===== design/pnf_root_stage.sv =====
// ----------------------------------------------------------------------------
// pnf_root_stage: one stage of the integer square root
// Resolves ROOT_ITERS result bits of the digit-by-digit root per stage.
// ----------------------------------------------------------------------------
module pnf_root_stage
  import pnf_pkg::*;
#(
  parameter int FIRST = 0
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  pnf_root_t  up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output pnf_root_t  dn_data
);

  pnf_root_t nxt;

  // ROOT_ITERS compare and subtract steps
  always_comb begin
    logic [63:0] bitv;
    nxt = up_data;
    for (int s = 0; s < ROOT_ITERS; s++) begin
      bitv = 64'(1) << (62 - 2 * (FIRST + s));
      if (nxt.rem >= nxt.root + bitv) begin
        nxt.rem  = nxt.rem - (nxt.root + bitv);
        nxt.root = (nxt.root >> 1) + bitv;
      end else begin
        nxt.root = nxt.root >> 1;
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready) begin
      dn_data <= nxt;
    end
  end

endmodule

// ===== design/pnf_back.sv =====
// ----------------------------------------------------------------------------
// pnf_back: force terms, sum and saturation
// Five stages: coefficient products, partial products, signed terms, sum,
// floor shift with saturation into the result register.
// ----------------------------------------------------------------------------
module pnf_back
  import pnf_pkg::*;
#(
  parameter int VALUE_FRAC_BITS = 16
)(
  input  logic       clk,
  input  logic       rst,
  input  pnf_coef_t  coef,
  input  logic       up_valid,
  output logic       up_ready,
  input  pnf_root_t  up_data,
  pnf_out_if.source  result_out
);

  localparam int SH = COEFF_FRAC_BITS + VALUE_FRAC_BITS;

  logic                     v1, v2, v3, v4;
  logic                     r1, r2, r3, r4, r5;
  // stage 1
  logic [63:0]              s1_dscale;
  logic [2:0][63:0]         s1_mlo;
  logic [2:0][63:0]         s1_mhi;
  val_t [2:0]               s1_vel;
  logic [2:0]               s1_cneg;
  // stage 2
  logic [2:0][63:0]         s2_dlo;
  logic [2:0][63:0]         s2_dhi;
  logic [2:0][95:0]         s2_mmag;
  logic [2:0]               s2_dneg;
  logic [2:0]               s2_cneg;
  // stage 3
  logic signed [SUM_W-1:0]  s3_mterm [3];
  logic [2:0][95:0]         s3_dmag;
  logic [2:0]               s3_dneg;
  // stage 4
  logic signed [SUM_W-1:0]  s4_sum [3];
  // comb
  logic [2:0][31:0]         vmag;
  logic signed [SUM_W-1:0]  gterm;
  logic signed [SUM_W-1:0]  mext [3];
  logic signed [SUM_W-1:0]  dext [3];
  logic signed [SUM_W-1:0]  shv [3];
  logic [2:0]               fits;
  val_t [2:0]               fval;

  // ready chain, output register last
  assign r5 = !result_out.valid || result_out.ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      result_out.valid <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) result_out.valid <= v4;
    end
  end

  // stage 1: drag scale and magnus partial products
  always_ff @(posedge clk) begin
    if (r1) begin
      s1_dscale <= 64'(coef.drag) * 64'(up_data.root[31:0]);
      for (int i = 0; i < 3; i++) begin
        s1_mlo[i] <= 64'(coef.magnus) * 64'(up_data.cmag[i][31:0]);
        s1_mhi[i] <= 64'(coef.magnus) * 64'(up_data.cmag[i][63:32]);
      end
      s1_vel  <= up_data.vel;
      s1_cneg <= up_data.cneg;
    end
  end

  // velocity magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i] = s1_vel[i][31] ? (~s1_vel[i] + 32'd1) : s1_vel[i];
    end
  end

  // stage 2: drag partial products, magnus magnitude
  always_ff @(posedge clk) begin
    if (r2) begin
      for (int i = 0; i < 3; i++) begin
        s2_dlo[i]  <= 64'(s1_dscale[31:0]) * 64'(vmag[i]);
        s2_dhi[i]  <= 64'(s1_dscale[63:32]) * 64'(vmag[i]);
        s2_mmag[i] <= 96'(s1_mlo[i]) + (96'(s1_mhi[i]) << 32);
        // drag opposes velocity
        s2_dneg[i] <= !s1_vel[i][31];
      end
      s2_cneg <= s1_cneg;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mext[i] = $signed(SUM_W'(s2_mmag[i]));
    end
  end

  // stage 3: signed magnus term, drag magnitude
  always_ff @(posedge clk) begin
    if (r3) begin
      for (int i = 0; i < 3; i++) begin
        s3_mterm[i] <= s2_cneg[i] ? -mext[i] : mext[i];
        s3_dmag[i]  <= 96'(s2_dlo[i]) + (96'(s2_dhi[i]) << 32);
      end
      s3_dneg <= s2_dneg;
    end
  end

  assign gterm = $signed(SUM_W'(coef.gravity)) <<< SH;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dext[i] = $signed(SUM_W'(s3_dmag[i]));
      if (s3_dneg[i]) dext[i] = -dext[i];
    end
  end

  // stage 4: exact sums, gravity on z only
  always_ff @(posedge clk) begin
    if (r4) begin
      s4_sum[0] <= s3_mterm[0] + dext[0];
      s4_sum[1] <= s3_mterm[1] + dext[1];
      s4_sum[2] <= s3_mterm[2] + dext[2] + gterm;
    end
  end

  // floor shift and range check
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shv[i]  = s4_sum[i] >>> SH;
      fits[i] = (&shv[i][SUM_W-1:31]) || !(|shv[i][SUM_W-1:31]);
      if (fits[i]) begin
        fval[i] = shv[i][31:0];
      end else if (shv[i][SUM_W-1]) begin
        fval[i] = 32'sh8000_0000;
      end else begin
        fval[i] = 32'sh7FFF_FFFF;
      end
    end
  end

  // stage 5: result register
  always_ff @(posedge clk) begin
    if (r5) begin
      result_out.force_x  <= fval[0];
      result_out.force_y  <= fval[1];
      result_out.force_z  <= fval[2];
      result_out.overflow <= !(&fits);
    end
  end

endmodule

// ===== design/projectile_net_force_top.sv =====
// Pipeline: 23 register stages from the input word to the result word:
//   2 front, 16 square root, 5 force.
// Throughput: one word per cycle; each stage holds one word and stalls
//   only when the stage after it is full.
// Reset: synchronous rst clears all stage valid bits and the coefficients.
// ----------------------------------------------------------------------------
// projectile_net_force_top: net force on a spinning projectile
// Gravity, quadratic drag and Magnus force, summed exactly and saturated.
// ----------------------------------------------------------------------------
module projectile_net_force_top
  import pnf_pkg::*;
#(
  parameter int VALUE_FRAC_BITS = 16
)(
  input  logic       clk,
  input  logic       rst,
  pnf_in_if.sink     item_in,
  pnf_out_if.source  result_out,
  pnf_cfg_if.sink    cfg
);

  pnf_coef_t  coef;
  logic       rt_v [ROOT_STAGES+1];
  logic       rt_r [ROOT_STAGES+1];
  pnf_root_t  rt_d [ROOT_STAGES+1];

  // coefficient registers, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_GRAVITY: coef.gravity <= cfg.wdata;
        CFG_DRAG:    coef.drag    <= cfg.wdata;
        CFG_MAGNUS:  coef.magnus  <= cfg.wdata;
        default: ;
      endcase
    end
  end

  pnf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_in),
    .dn_valid (rt_v[0]),
    .dn_ready (rt_r[0]),
    .dn_data  (rt_d[0])
  );

  // square root pipeline
  for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
    pnf_root_stage #(.FIRST(g * ROOT_ITERS)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (rt_v[g]),
      .up_ready (rt_r[g]),
      .up_data  (rt_d[g]),
      .dn_valid (rt_v[g+1]),
      .dn_ready (rt_r[g+1]),
      .dn_data  (rt_d[g+1])
    );
  end

  pnf_back #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .up_valid   (rt_v[ROOT_STAGES]),
    .up_ready   (rt_r[ROOT_STAGES]),
    .up_data    (rt_d[ROOT_STAGES]),
    .result_out (result_out)
  );

endmodule

// ===== design/pnf_checker.sv =====
// ----------------------------------------------------------------------------
// pnf_checker: port level checks for the net force block
// Reset, stall hold, saturation flag and configuration ready.
// ----------------------------------------------------------------------------
module pnf_checker
  import pnf_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input val_t force_x,
  input val_t force_y,
  input val_t force_z,
  input logic overflow,
  input logic cfg_ready
);

  localparam val_t VMAX = 32'sh7FFF_FFFF;
  localparam val_t VMIN = 32'sh8000_0000;

  // no result word straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(force_x) &&
      $stable(force_y) && $stable(force_z) && $stable(overflow))
    else $error("stalled result changed");

  // saturation flag only with a clamped component
  a_ovf_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> force_x == VMAX || force_x == VMIN ||
      force_y == VMAX || force_y == VMIN || force_z == VMAX || force_z == VMIN)
    else $error("overflow without clamped component");

  // configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind projectile_net_force_top pnf_checker u_pnf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .force_x   (result_out.force_x),
  .force_y   (result_out.force_y),
  .force_z   (result_out.force_z),
  .overflow  (result_out.overflow),
  .cfg_ready (cfg.ready)
);

// ===== bench/pnf_force_checker.sv =====
// ----------------------------------------------------------------------------
// pnf_force_checker: scoreboard for the projectile net force pipeline
// Watches the configuration, input and result channels. Keeps its own copy
// of the coefficients, works out the net force of every accepted input word
// and compares each result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pnf_force_checker
  import pnf_pkg::*;
#(
  parameter int VALUE_FRAC_BITS = 16
)(
  input  logic clk,
  input  logic rst,
  pnf_in_if    item_mon,
  pnf_out_if   result_mon,
  pnf_cfg_if   cfg_mon,
  output int   mismatches,
  output int   pending
);

  localparam int SUM_SHIFT = COEFF_FRAC_BITS + VALUE_FRAC_BITS;

  typedef struct {
    val_t fx;
    val_t fy;
    val_t fz;
    logic ovf;
  } net_force_t;

  pnf_coef_t  coef_copy;
  net_force_t force_fifo[$];

  // integer square root, floor
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor shift then clamp to 32 bits
  function automatic val_t clamp_force(input logic signed [127:0] s, inout logic ovf);
    logic signed [127:0] q;
    q = s >>> SUM_SHIFT;
    if (q > 128'sh7FFFFFFF) begin
      ovf = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (q < -128'sh80000000) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  // gravity + drag + magnus, summed exactly
  function automatic net_force_t net_force(input val_t vel[3], input val_t spin[3],
                                           input pnf_coef_t c);
    net_force_t          res;
    logic [63:0]         sq;
    logic [63:0]         speed;
    logic [63:0]         dscale;
    longint              p;
    logic signed [127:0] v[3];
    logic signed [127:0] w[3];
    logic signed [127:0] cross_p;
    logic signed [127:0] sum;
    logic signed [127:0] mag_c;
    logic signed [127:0] drag_s;
    logic signed [127:0] grav;
    val_t                comp[3];
    int                  j;
    int                  k;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      v[i] = vel[i];
      w[i] = spin[i];
      p = longint'(vel[i]) * longint'(vel[i]);
      sq = sq + 64'(p);
    end
    speed  = floor_sqrt(sq);
    dscale = {32'd0, c.drag} * speed;
    mag_c  = signed'({96'd0, c.magnus});
    drag_s = signed'({64'd0, dscale});
    grav   = c.gravity;
    grav   = grav <<< SUM_SHIFT;
    res.ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      cross_p = w[j] * v[k] - w[k] * v[j];
      sum = mag_c * cross_p - drag_s * v[i];
      if (i == 2) sum = sum + grav;
      comp[i] = clamp_force(sum, res.ovf);
    end
    res.fx = comp[0];
    res.fy = comp[1];
    res.fz = comp[2];
    return res;
  endfunction

  assign pending = force_fifo.size();

  // monitor all three channels
  always @(posedge clk) begin
    net_force_t exp_f;
    val_t       vel[3];
    val_t       spin[3];
    int         errs;
    errs = 0;
    if (rst) begin
      coef_copy  <= '0;
      mismatches <= 0;
      force_fifo.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_GRAVITY: coef_copy.gravity <= cfg_mon.wdata;
          CFG_DRAG:    coef_copy.drag    <= cfg_mon.wdata;
          CFG_MAGNUS:  coef_copy.magnus  <= cfg_mon.wdata;
          default: ;
        endcase
      end
      if (result_mon.valid && result_mon.ready) begin
        if (force_fifo.size() == 0) begin
          $error("result word with no prediction waiting");
          errs = errs + 1;
        end else begin
          exp_f = force_fifo.pop_front();
          if (result_mon.force_x !== exp_f.fx) begin
            $error("force_x: expected %0d, got %0d", exp_f.fx, result_mon.force_x);
            errs = errs + 1;
          end
          if (result_mon.force_y !== exp_f.fy) begin
            $error("force_y: expected %0d, got %0d", exp_f.fy, result_mon.force_y);
            errs = errs + 1;
          end
          if (result_mon.force_z !== exp_f.fz) begin
            $error("force_z: expected %0d, got %0d", exp_f.fz, result_mon.force_z);
            errs = errs + 1;
          end
          if (result_mon.overflow !== exp_f.ovf) begin
            $error("overflow: expected %0b, got %0b", exp_f.ovf, result_mon.overflow);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) begin
        mismatches <= mismatches + errs;
      end
      if (item_mon.valid && item_mon.ready) begin
        vel[0]  = item_mon.vel_x;
        vel[1]  = item_mon.vel_y;
        vel[2]  = item_mon.vel_z;
        spin[0] = item_mon.spin_x;
        spin[1] = item_mon.spin_y;
        spin[2] = item_mon.spin_z;
        force_fifo.push_back(net_force(vel, spin, coef_copy));
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: top level bench for projectile_net_force_top
// Drives configuration phases (defaults, extremes, random coefficients),
// a directed set of velocity/spin words and bursts of random words, with a
// stalling receiver. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import pnf_pkg::*;

  localparam int N_PHASES    = 6;
  localparam int RAND_PER_PH = 192;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 30;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   words_sent;
  int   burst_left;
  int   idle_cycles;
  int   stall_left;
  int   stall_mode;

  pnf_in_if  in_ch ();
  pnf_out_if out_ch ();
  pnf_cfg_if cfg_ch ();

  projectile_net_force_top u_top (
    .clk        (clk),
    .rst        (rst),
    .item_in    (in_ch),
    .result_out (out_ch),
    .cfg        (cfg_ch)
  );

  pnf_force_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .item_mon   (in_ch),
    .result_mon (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver stalls on patterns of changing length
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      stall_mode   <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(5, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 0);
        2: out_ch.ready <= ($urandom_range(0, 4) == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog on channel activity
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // random field value, biased towards physical magnitudes
  function automatic val_t rand_field();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {{16{1'b0}}, 16'($urandom)} - 32'sd32768;
      4, 5:       return val_t'($signed(24'($urandom)));
      6, 7:       return val_t'($urandom);
      8: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sd1;
          3: return -32'sd1;
          default: return 32'sh00010000;
        endcase
      end
      default: return '0;
    endcase
  endfunction

  // valid is left high; the caller drops it after the last write
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // send one word, bursts with random gaps
  task automatic send_word(input val_t vx, input val_t vy, input val_t vz,
                           input val_t wx, input val_t wy, input val_t wz);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid  <= 1'b1;
    in_ch.vel_x  <= vx;
    in_ch.vel_y  <= vy;
    in_ch.vel_z  <= vz;
    in_ch.spin_x <= wx;
    in_ch.spin_y <= wy;
    in_ch.spin_z <= wz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left = burst_left - 1;
    words_sent = words_sent + 1;
  endtask

  task automatic send_random();
    send_word(rand_field(), rand_field(), rand_field(),
              rand_field(), rand_field(), rand_field());
  endtask

  localparam val_t VMAX = 32'sh7FFFFFFF;
  localparam val_t VMIN = 32'sh80000000;

  initial begin
    logic [31:0] g;
    logic [31:0] d;
    logic [31:0] m;
    words_sent   = 0;
    burst_left   = 0;
    in_ch.valid  = 1'b0;
    in_ch.vel_x  = '0;
    in_ch.vel_y  = '0;
    in_ch.vel_z  = '0;
    in_ch.spin_x = '0;
    in_ch.spin_y = '0;
    in_ch.spin_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_GRAVITY;
    cfg_ch.wdata = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients are zero: only the zero force can come out
    send_word(VMAX, VMIN, 32'sd12345, VMIN, VMAX, -32'sd7);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin g = -32'sd93225; d = 32'h0001_2000; m = 32'h0000_4000; end
        1: begin g = '0;          d = '0;            m = '0;            end
        2: begin g = 32'h7FFFFFFF; d = 32'hFFFFFFFF; m = 32'hFFFFFFFF; end
        3: begin g = 32'h80000000; d = $urandom;     m = $urandom;     end
        default: begin g = $urandom; d = $urandom >> $urandom_range(0, 24);
                       m = $urandom >> $urandom_range(0, 24); end
      endcase
      cfg_write(CFG_GRAVITY, g);
      cfg_write(CFG_DRAG, d);
      cfg_write(CFG_MAGNUS, m);
      // index beyond the register list is ignored
      cfg_write(2'd3, $urandom);
      cfg_ch.valid <= 1'b0;

      if (ph == 0) begin
        // zero speed, unit vectors, extremes, pure spin, pure velocity
        send_word('0, '0, '0, '0, '0, '0);
        send_word('0, '0, '0, VMAX, VMIN, VMAX);
        send_word(32'sh00010000, '0, '0, '0, '0, '0);
        send_word('0, -32'sh00010000, '0, '0, '0, '0);
        send_word('0, '0, 32'sh00010000, 32'sh00010000, '0, '0);
        send_word(32'sd1, 32'sd1, 32'sd1, -32'sd1, -32'sd1, -32'sd1);
        send_word(VMAX, VMAX, VMAX, '0, '0, '0);
        send_word(VMIN, VMIN, VMIN, '0, '0, '0);
        send_word(VMAX, VMIN, VMAX, VMIN, VMAX, VMIN);
        send_word(VMIN, VMAX, VMIN, VMAX, VMIN, VMAX);
        send_word(32'sh00280000, 32'sh00030000, -32'sh00050000,
                  32'sh00000000, 32'sh01F40000, -32'sh00640000);
        send_word(-32'sh00280000, 32'sh00000000, 32'sh00140000,
                  32'sh0BB80000, 32'sh00000000, 32'sh00000000);
        send_word(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                  32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF);
        send_word(32'h0000FFFF, 32'hFFFF0000, 32'h00FF00FF,
                  32'hFF00FF00, 32'h0F0F0F0F, 32'hF0F0F0F0);
      end

      for (int n = 0; n < RAND_PER_PH; n++) begin
        send_random();
        // hold off once until the pipeline has emptied
        if (ph == 4 && n == RAND_PER_PH / 2) begin
          in_ch.valid <= 1'b0;
          burst_left = 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    $display("Covered %0d words over %0d coefficient settings (zero, extreme, random),",
             words_sent, N_PHASES + 1);
    $display("with bursty input, stalling output and saturating sums.");
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== projectile_net_force_top.f =====
design/pnf_pkg.sv
design/pnf_if.sv
design/pnf_front.sv
design/pnf_root_stage.sv
design/pnf_back.sv
design/projectile_net_force_top.sv
design/pnf_checker.sv
bench/pnf_force_checker.sv
bench/tb.sv
